// ===== design/two_axis_bang_bang_positioner_core_macros.svh =====
// Assertion helpers for the positioner core RTL.
`ifndef TWO_AXIS_BANG_BANG_POSITIONER_CORE_MACROS_SVH
`define TWO_AXIS_BANG_BANG_POSITIONER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define TBBP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define TBBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tbbp_pkg.sv =====
package tbbp_pkg;

    localparam int POS_W  = 32;
    localparam int ERR_W  = POS_W + 1;
    localparam int DUTY_W = 16;
    localparam int TOL_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [TOL_W-1:0]  TOL_RESET  = 16'd10;
    localparam logic [DUTY_W-1:0] DUTY_RESET = 16'd500;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_DUTY = 2'd1;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_SET   = 2'd1,
        FUNC_START = 2'd2,
        FUNC_STOP  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_MOVING  = 3'd1,
        MODE_READY   = 3'd2,
        MODE_WARN_X  = 3'd3,
        MODE_WARN_Y  = 3'd4,
        MODE_WARN_XY = 3'd5
    } mode_t;

    // Per-axis control decoded from the command.
    typedef struct packed {
        logic upd_tick;    // regulate this axis
        logic zero_drive;  // force drive to zero
        logic ld_target;   // goal <= target
        logic ld_count;    // goal <= count
        logic clr_goal;    // goal <= 0
    } lane_ctl_t;

    typedef struct packed {
        mode_t             ctl_state;
        logic [DUTY_W-1:0] duty_x;
        logic              dir_x;
        logic [DUTY_W-1:0] duty_y;
        logic              dir_y;
        logic              motors_on;
    } res_t;

endpackage

// ===== design/tbbp_lane.sv =====
module tbbp_lane
    import tbbp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  lane_ctl_t               ctl,
    input  logic signed [POS_W-1:0] target,
    input  logic signed [POS_W-1:0] count,
    input  logic [TOL_W-1:0]        tol,
    input  logic [DUTY_W-1:0]       duty,
    output logic                    in_band,
    output logic [DUTY_W-1:0]       drive_next,
    output logic                    heading_next,
    output logic [DUTY_W-1:0]       drive
);

    logic signed [POS_W-1:0] goal_reg;
    logic signed [POS_W-1:0] goal_next;
    logic [DUTY_W-1:0]       drive_reg;
    logic                    heading_reg;
    logic signed [ERR_W-1:0] err;
    logic signed [ERR_W-1:0] tol_s;

    // Exact 33-bit error, no wrap.
    assign err     = {goal_reg[POS_W-1], goal_reg} - {count[POS_W-1], count};
    assign tol_s   = {{(ERR_W-TOL_W){1'b0}}, tol};
    assign in_band = (err <= tol_s) && (err >= -tol_s);

    always_comb
    begin
        goal_next    = goal_reg;
        drive_next   = drive_reg;
        heading_next = heading_reg;
        if (ctl.ld_target)
        begin
            goal_next = target;
        end
        else if (ctl.ld_count)
        begin
            goal_next = count;
        end
        else if (ctl.clr_goal)
        begin
            goal_next = '0;
        end
        if (ctl.zero_drive)
        begin
            drive_next = '0;
        end
        else if (ctl.upd_tick)
        begin
            if (in_band)
            begin
                drive_next = '0;
            end
            else
            begin
                drive_next   = duty;
                heading_next = ~err[ERR_W-1];  // outside window, so nonzero
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            goal_reg    <= '0;
            drive_reg   <= '0;
            heading_reg <= 1'b0;
        end
        else
        begin
            goal_reg    <= goal_next;
            drive_reg   <= drive_next;
            heading_reg <= heading_next;
        end
    end

    assign drive = drive_reg;

endmodule

// ===== design/tbbp_skid.sv =====
module tbbp_skid
    import tbbp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  res_t in_data,
    output logic out_valid,
    input  logic out_ready,
    output res_t out_data
);

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_data_reg;
    res_t skid_data_reg;
    logic accept;

    assign in_ready = ~skid_valid_reg;
    assign accept   = in_valid & in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= accept;
            end
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end
        else if (accept)
        begin
            skid_data_reg <= in_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/two_axis_bang_bang_positioner_core.sv =====
// Two-axis bang-bang positioner with deadband.
// Input channel (in_valid/in_ready): one beat per command - tick, set targets,
// start or stop - plus both encoder counts and both limit-switch levels.
// Output channel (out_valid/out_ready): one result beat per input beat, giving
// mode, duty and direction per axis and motors_on, as left by that command.
// Config channel (cfg_valid/cfg_ready): index 0 tolerance, 1 move duty; always
// ready, other indexes are dropped. Write only while the block is idle.
// Results are registered; a beat waits in the skid entry while out_ready is low.
// Throughput: one beat per cycle while in_ready is high; the X and Y lanes each
// form a 33-bit error and window compare at accept; the merge picks the mode.
// Stall: a two-entry output (register plus skid) takes one more beat while
// out_ready is low; in_ready drops only once both entries are full.
// Reset: mode idle, goals, drives, headings and motors_on cleared; tolerance
// back to 10, move duty to 500; no results pending.
module two_axis_bang_bang_positioner_core
    import tbbp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // config
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [DUTY_W-1:0]       cfg_data,
    // command in
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              func,
    input  logic signed [POS_W-1:0] target_x,
    input  logic signed [POS_W-1:0] target_y,
    input  logic signed [POS_W-1:0] count_x,
    input  logic signed [POS_W-1:0] count_y,
    input  logic                    warn_x,
    input  logic                    warn_y,
    // result out
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0]              ctl_state,
    output logic [DUTY_W-1:0]       duty_x,
    output logic                    dir_x,
    output logic [DUTY_W-1:0]       duty_y,
    output logic                    dir_y,
    output logic                    motors_on
);

`include "two_axis_bang_bang_positioner_core_macros.svh"

    logic [TOL_W-1:0]  tol_reg;
    logic [DUTY_W-1:0] duty_reg;
    mode_t             mode_reg;
    mode_t             mode_next;
    logic              running_reg;
    logic              running_next;

    func_t     cmd;
    logic      in_fire;
    logic      any_warn;
    mode_t     warn_mode;
    lane_ctl_t lane_ctl;

    logic              inside_x;
    logic              inside_y;
    logic [DUTY_W-1:0] drive_x_next;
    logic [DUTY_W-1:0] drive_y_next;
    logic              heading_x_next;
    logic              heading_y_next;
    logic [DUTY_W-1:0] drive_x_cur;
    logic [DUTY_W-1:0] drive_y_cur;

    res_t res_in;
    res_t res_out;

    // Config registers: always ready, unknown index ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg  <= TOL_RESET;
            duty_reg <= DUTY_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IDX_TOL:  tol_reg  <= cfg_data;
                CFG_IDX_DUTY: duty_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign cmd      = func_t'(func);
    assign in_fire  = in_valid & in_ready;
    assign any_warn = warn_x | warn_y;

    always_comb
    begin
        if (warn_x && warn_y)
        begin
            warn_mode = MODE_WARN_XY;
        end
        else if (warn_x)
        begin
            warn_mode = MODE_WARN_X;
        end
        else
        begin
            warn_mode = MODE_WARN_Y;
        end
    end

    // Command decode shared by both lanes. Gated by in_fire so state only
    // moves on an accepted beat.
    always_comb
    begin
        lane_ctl = '0;
        if (in_fire)
        begin
            case (cmd)
                FUNC_TICK:
                begin
                    lane_ctl.zero_drive = any_warn;
                    lane_ctl.upd_tick   = !any_warn && (mode_reg == MODE_MOVING);
                end
                FUNC_SET:
                begin
                    lane_ctl.ld_target  = 1'b1;
                    lane_ctl.zero_drive = any_warn;
                end
                FUNC_START:
                begin
                    lane_ctl.ld_count   = 1'b1;
                    lane_ctl.zero_drive = 1'b1;
                end
                FUNC_STOP:
                begin
                    lane_ctl.clr_goal   = 1'b1;
                    lane_ctl.zero_drive = 1'b1;
                end
                default:
                begin
                    lane_ctl = '0;
                end
            endcase
        end
    end

    tbbp_lane u_lane_x (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (lane_ctl),
        .target       (target_x),
        .count        (count_x),
        .tol          (tol_reg),
        .duty         (duty_reg),
        .in_band      (inside_x),
        .drive_next   (drive_x_next),
        .heading_next (heading_x_next),
        .drive        (drive_x_cur)
    );

    tbbp_lane u_lane_y (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (lane_ctl),
        .target       (target_y),
        .count        (count_y),
        .tol          (tol_reg),
        .duty         (duty_reg),
        .in_band      (inside_y),
        .drive_next   (drive_y_next),
        .heading_next (heading_y_next),
        .drive        (drive_y_cur)
    );

    // Merge: mode and motors_on from the command and both lane window flags.
    always_comb
    begin
        mode_next    = mode_reg;
        running_next = running_reg;
        if (in_fire)
        begin
            case (cmd)
                FUNC_TICK:
                begin
                    if (any_warn)
                    begin
                        mode_next = warn_mode;
                    end
                    else if (mode_reg == MODE_MOVING && inside_x && inside_y)
                    begin
                        mode_next = MODE_READY;
                    end
                end
                FUNC_SET:
                begin
                    mode_next = any_warn ? warn_mode : MODE_MOVING;
                end
                FUNC_START:
                begin
                    mode_next    = MODE_IDLE;
                    running_next = 1'b1;
                end
                FUNC_STOP:
                begin
                    mode_next    = MODE_IDLE;
                    running_next = 1'b0;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            running_reg <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            running_reg <= running_next;
        end
    end

    // Result reflects state after the command.
    always_comb
    begin
        res_in.ctl_state = mode_next;
        res_in.duty_x    = drive_x_next;
        res_in.dir_x     = heading_x_next;
        res_in.duty_y    = drive_y_next;
        res_in.dir_y     = heading_y_next;
        res_in.motors_on = running_next;
    end

    tbbp_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (res_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (res_out)
    );

    assign ctl_state = res_out.ctl_state;
    assign duty_x    = res_out.duty_x;
    assign dir_x     = res_out.dir_x;
    assign duty_y    = res_out.duty_y;
    assign dir_y     = res_out.dir_y;
    assign motors_on = res_out.motors_on;

    // Only the moving mode may hold a nonzero drive.
    `TBBP_ASSERT_SAME(a_drive_only_moving, mode_reg != MODE_MOVING,
        drive_x_cur == '0 && drive_y_cur == '0, "drive active outside moving mode")
    // Start turns the motors on and parks in idle.
    `TBBP_ASSERT_NEXT(a_start_runs, in_fire && cmd == FUNC_START,
        running_reg && mode_reg == MODE_IDLE, "start did not enable motors")
    // Stop turns the motors off and parks in idle.
    `TBBP_ASSERT_NEXT(a_stop_halts, in_fire && cmd == FUNC_STOP,
        !running_reg && mode_reg == MODE_IDLE, "stop did not disable motors")
    // Input backpressure only when a result is already waiting.
    `TBBP_ASSERT_SAME(a_backpressure, !in_ready, out_valid,
        "input stalled with no result pending")

endmodule

// ===== verif/tb.sv =====
// Self-checking bench for the two-axis bang-bang positioner.
// Command beats come from a queue filled by the stimulus thread. The driver
// pops them, and each accepted beat is run through a local model of the
// positioner. The model pushes the expected state/drive beat, and the result
// monitor checks it field by field against the oldest one waiting.
module tb;
    import tbbp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PARK_CYCLES = 80;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 8;    // settle time after the last result
    localparam int MAX_SHOWN = 10;

    // Indexes the block drops; written only to exercise the upper index bit.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    typedef struct {
        func_t                   fn;
        logic signed [POS_W-1:0] tx;
        logic signed [POS_W-1:0] ty;
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic                    wx;
        logic                    wy;
    } cmd_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports (driven inputs start at known values)
    // ------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [DUTY_W-1:0]       cfg_data = '0;

    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [1:0]              func = FUNC_TICK;
    logic signed [POS_W-1:0] target_x = '0;
    logic signed [POS_W-1:0] target_y = '0;
    logic signed [POS_W-1:0] count_x = '0;
    logic signed [POS_W-1:0] count_y = '0;
    logic                    warn_x = 1'b0;
    logic                    warn_y = 1'b0;

    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [2:0]              ctl_state;
    logic [DUTY_W-1:0]       duty_x;
    logic                    dir_x;
    logic [DUTY_W-1:0]       duty_y;
    logic                    dir_y;
    logic                    motors_on;

    two_axis_bang_bang_positioner_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .target_x  (target_x),
        .target_y  (target_y),
        .count_x   (count_x),
        .count_y   (count_y),
        .warn_x    (warn_x),
        .warn_y    (warn_y),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl_state (ctl_state),
        .duty_x    (duty_x),
        .dir_x     (dir_x),
        .duty_y    (duty_y),
        .dir_y     (dir_y),
        .motors_on (motors_on)
    );

    initial
    begin : clock_gen
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Positioner model: state and register copies, reset values up front
    // ------------------------------------------------------------------
    mode_t                   pm_mode = MODE_IDLE;
    logic signed [POS_W-1:0] pm_goal_x = '0;
    logic signed [POS_W-1:0] pm_goal_y = '0;
    logic [DUTY_W-1:0]       pm_drive_x = '0;
    logic [DUTY_W-1:0]       pm_drive_y = '0;
    logic                    pm_head_x = 1'b0;
    logic                    pm_head_y = 1'b0;
    logic                    pm_running = 1'b0;
    logic [TOL_W-1:0]        pm_tol = TOL_RESET;
    logic [DUTY_W-1:0]       pm_duty = DUTY_RESET;

    res_t motor_cmd_q[$];   // predicted state/drive beats, oldest first
    cmd_t command_q[$];     // command beats not yet offered

    // Pressed switch: both drives off, mode picks the warning code.
    function automatic logic trip_on_switch(input logic wx, input logic wy);
        if (!wx && !wy)
            return 1'b0;
        pm_drive_x = '0;
        pm_drive_y = '0;
        if (wx && wy)
            pm_mode = MODE_WARN_XY;
        else if (wx)
            pm_mode = MODE_WARN_X;
        else
            pm_mode = MODE_WARN_Y;
        return 1'b1;
    endfunction

    // One axis of the bang-bang law; error is formed in 33 bits, no wrap.
    task automatic regulate_axis(input logic signed [POS_W-1:0] goal,
                                 input logic signed [POS_W-1:0] count,
                                 inout logic [DUTY_W-1:0] drive,
                                 inout logic heading,
                                 output logic settled);
        logic signed [ERR_W-1:0] err;
        logic signed [ERR_W-1:0] band;
        err = {goal[POS_W-1], goal} - {count[POS_W-1], count};
        band = {{(ERR_W-TOL_W){1'b0}}, pm_tol};
        settled = (err >= -band) && (err <= band);
        if (settled)
        begin
            drive = '0;
        end
        else
        begin
            heading = (err > 0);
            drive = pm_duty;
        end
    endtask

    // Apply one command beat and queue the beat the block should return.
    task automatic advance_positioner(input cmd_t c);
        logic settled_x;
        logic settled_y;
        res_t r;
        case (c.fn)
            FUNC_TICK:
            begin
                // ticks only regulate in moving mode; warning stays sticky
                if (!trip_on_switch(c.wx, c.wy) && pm_mode == MODE_MOVING)
                begin
                    regulate_axis(pm_goal_x, c.cx, pm_drive_x, pm_head_x, settled_x);
                    regulate_axis(pm_goal_y, c.cy, pm_drive_y, pm_head_y, settled_y);
                    if (settled_x && settled_y)
                        pm_mode = MODE_READY;
                end
            end
            FUNC_SET:
            begin
                // accepted even with motors off
                pm_goal_x = c.tx;
                pm_goal_y = c.ty;
                if (!trip_on_switch(c.wx, c.wy))
                    pm_mode = MODE_MOVING;
            end
            FUNC_START:
            begin
                pm_running = 1'b1;
                pm_drive_x = '0;
                pm_drive_y = '0;
                pm_goal_x = c.cx;
                pm_goal_y = c.cy;
                pm_mode = MODE_IDLE;
            end
            default:
            begin
                pm_running = 1'b0;
                pm_drive_x = '0;
                pm_drive_y = '0;
                pm_goal_x = '0;
                pm_goal_y = '0;
                pm_mode = MODE_IDLE;
            end
        endcase
        r.ctl_state = pm_mode;
        r.duty_x = pm_drive_x;
        r.dir_x = pm_head_x;
        r.duty_y = pm_drive_y;
        r.dir_y = pm_head_y;
        r.motors_on = pm_running;
        motor_cmd_q.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Pacing knobs, set by the stimulus thread at the falling edge
    // ------------------------------------------------------------------
    int in_idle_pct = 0;     // chance of starting a sender gap per beat slot
    int out_idle_pct = 0;    // chance of starting a receiver stall per cycle
    int in_gap = 0;
    int out_gap = 0;
    int park_left = 0;
    logic park_req = 1'b0;

    int fail_cnt = 0;
    int result_idx = 0;
    int cycle_cnt = 0;
    cmd_t cur_cmd;           // beat now on the input ports

    // ------------------------------------------------------------------
    // Driver: present queued command beats, predict on each accept
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_commands
        cmd_t nxt;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                advance_positioner(cur_cmd);
            // a new beat (or a gap) only when the port is free
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap--;
                    in_valid <= 1'b0;
                end
                else if (command_q.size() != 0 && in_idle_pct != 0 &&
                         $urandom_range(1, 100) <= in_idle_pct)
                begin
                    in_gap = $urandom_range(1, 11) - 1;
                    in_valid <= 1'b0;
                end
                else if (command_q.size() != 0)
                begin
                    nxt = command_q.pop_front();
                    cur_cmd = nxt;
                    in_valid <= 1'b1;
                    func <= nxt.fn;
                    target_x <= nxt.tx;
                    target_y <= nxt.ty;
                    count_x <= nxt.cx;
                    count_y <= nxt.cy;
                    warn_x <= nxt.wx;
                    warn_y <= nxt.wy;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver back-pressure
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fail_cnt++;
            if (fail_cnt <= MAX_SHOWN)
                $display("mismatch on %s, result %0d: expected %0h, got %0h",
                         name, result_idx, want, got);
        end
    endtask

    always @(posedge clk)
    begin : collect_results
        res_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (motor_cmd_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_SHOWN)
                        $display("result beat %0d arrived with nothing pending",
                                 result_idx);
                end
                else
                begin
                    want = motor_cmd_q.pop_front();
                    check_field("ctl_state", 32'(want.ctl_state), 32'(ctl_state));
                    check_field("duty_x", 32'(want.duty_x), 32'(duty_x));
                    check_field("dir_x", 32'(want.dir_x), 32'(dir_x));
                    check_field("duty_y", 32'(want.duty_y), 32'(duty_y));
                    check_field("dir_y", 32'(want.dir_y), 32'(dir_y));
                    check_field("motors_on", 32'(want.motors_on), 32'(motors_on));
                end
                result_idx++;
            end
            // long park first, then short random stalls
            if (park_left > 0)
            begin
                park_left--;
                out_ready <= 1'b0;
            end
            else if (park_req)
            begin
                park_req = 1'b0;
                park_left = PARK_CYCLES - 1;
                out_ready <= 1'b0;
            end
            else if (out_gap > 0)
            begin
                out_gap--;
                out_ready <= 1'b0;
            end
            else if (out_idle_pct != 0 && $urandom_range(1, 100) <= out_idle_pct)
            begin
                out_gap = $urandom_range(1, 11) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin : watchdog
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("tb failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0] gen_goal_x = '0;   // goals as the generator sees them
    logic signed [POS_W-1:0] gen_goal_y = '0;
    logic [TOL_W-1:0]        gen_tol = TOL_RESET;

    function automatic cmd_t mk_cmd(input func_t fn,
                                    input logic signed [POS_W-1:0] tx,
                                    input logic signed [POS_W-1:0] ty,
                                    input logic signed [POS_W-1:0] cx,
                                    input logic signed [POS_W-1:0] cy,
                                    input logic wx, input logic wy);
        cmd_t c;
        c.fn = fn;
        c.tx = tx;
        c.ty = ty;
        c.cx = cx;
        c.cy = cy;
        c.wx = wx;
        c.wy = wy;
        return c;
    endfunction

    // Queue a beat and track where the goals will end up.
    function automatic void push_cmd(input cmd_t c);
        case (c.fn)
            FUNC_SET:
            begin
                gen_goal_x = c.tx;
                gen_goal_y = c.ty;
            end
            FUNC_START:
            begin
                gen_goal_x = c.cx;
                gen_goal_y = c.cy;
            end
            FUNC_STOP:
            begin
                gen_goal_x = '0;
                gen_goal_y = '0;
            end
            default: ;
        endcase
        command_q.push_back(c);
    endfunction

    function automatic logic signed [POS_W-1:0] rand_pos();
        case ($urandom_range(0, 9))
            0: return POS_MAX;
            1: return POS_MIN;
            2, 3, 4: return $urandom_range(0, 4000) - 2000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic rare_warn();
        return ($urandom_range(0, 24) == 0);
    endfunction

    // Encoder count around a goal: inside, on the edge of, or far outside
    // the deadband. Settling ticks stay inside, at the edge or just past it.
    function automatic logic signed [POS_W-1:0] near_goal(
        input logic signed [POS_W-1:0] goal, input logic settle);
        longint off;
        int sel;
        sel = settle ? $urandom_range(0, 1) : $urandom_range(0, 5);
        case (sel)
            0: off = $urandom_range(0, gen_tol);
            1: off = gen_tol + $urandom_range(0, 1);
            default: off = gen_tol + 1 + $urandom_range(0, 1 << 20);
        endcase
        if ($urandom_range(0, 1))
            off = -off;
        return goal + POS_W'(off);
    endfunction

    // Mostly set-then-approach move sequences, some start/stop, some noise.
    task automatic queue_random(input int n);
        int made;
        int pick;
        int ticks;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    push_cmd(mk_cmd(FUNC_START, rand_pos(), rand_pos(), rand_pos(),
                                    rand_pos(), rare_warn(), rare_warn()));
                    made++;
                end
                push_cmd(mk_cmd(FUNC_SET, rand_pos(), rand_pos(), rand_pos(),
                                rand_pos(), rare_warn(), rare_warn()));
                made++;
                ticks = $urandom_range(1, 8);
                for (int i = 0; i < ticks; i++)
                begin
                    push_cmd(mk_cmd(FUNC_TICK, rand_pos(), rand_pos(),
                                    near_goal(gen_goal_x, i == ticks - 1),
                                    near_goal(gen_goal_y, i == ticks - 1),
                                    rare_warn(), rare_warn()));
                    made++;
                end
            end
            else if (pick < 75)
            begin
                push_cmd(mk_cmd($urandom_range(0, 1) ? FUNC_START : FUNC_STOP,
                                rand_pos(), rand_pos(), rand_pos(), rand_pos(),
                                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
                made++;
            end
            else
            begin
                push_cmd(mk_cmd(func_t'($urandom_range(0, 3)), $urandom, $urandom,
                                $urandom, $urandom, 1'($urandom_range(0, 1)),
                                1'($urandom_range(0, 1))));
                made++;
            end
        end
    endtask

    // Register write beat; the model copy follows on the accepting edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [DUTY_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_IDX_TOL: pm_tol = data;
            CFG_IDX_DUTY: pm_duty = data;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Sender pause: nothing queued, nothing offered, nothing owed.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (command_q.size() != 0 || in_valid || motor_cmd_q.size() != 0);
    endtask

    task automatic run_phase(input logic [TOL_W-1:0] tol, input logic [DUTY_W-1:0] duty,
                             input int in_pct, input int out_pct,
                             input logic park, input int n);
        write_reg(CFG_IDX_TOL, tol);
        write_reg(CFG_IDX_DUTY, duty);
        @(negedge clk);
        gen_tol = tol;
        in_idle_pct = in_pct;
        out_idle_pct = out_pct;
        park_req = park;
        queue_random(n);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        in_idle_pct = 15;
        out_idle_pct = 15;

        // reset registers: tolerance 10, duty 500
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, POS_MAX, POS_MIN, 1'b0, 1'b0));  // idle tick
        push_cmd(mk_cmd(FUNC_SET, POS_MAX, POS_MIN, '0, '0, 1'b0, 1'b0));
        // widest errors: +/-(2^32-1), must not wrap
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, POS_MIN, POS_MAX, 1'b0, 1'b0));
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, '0, '0, 1'b1, 1'b0));
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, '0, '0, 1'b0, 1'b0));  // warning sticks
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, '0, '0, 1'b0, 1'b1));
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, '0, '0, 1'b1, 1'b1));
        push_cmd(mk_cmd(FUNC_SET, 32'sd100, -32'sd100, '0, '0, 1'b0, 1'b1));
        push_cmd(mk_cmd(FUNC_SET, 32'sd100, -32'sd100, '0, '0, 1'b0, 1'b0));
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, 32'sd110, -32'sd110, 1'b0, 1'b0));  // on edge
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, '0, '0, 1'b0, 1'b0));  // ready: no action
        push_cmd(mk_cmd(FUNC_SET, 32'sd100, -32'sd100, '0, '0, 1'b0, 1'b0));
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, 32'sd111, -32'sd111, 1'b0, 1'b0));  // just out
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, 32'sd90, -32'sd90, 1'b0, 1'b0));
        push_cmd(mk_cmd(FUNC_START, '0, '0, 32'sd5000, -32'sd5000, 1'b1, 1'b1));
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, 32'sd5000, -32'sd5000, 1'b0, 1'b0));
        push_cmd(mk_cmd(FUNC_STOP, POS_MAX, POS_MIN, POS_MAX, POS_MIN, 1'b1, 1'b1));
        // motors off, still commanded to move
        push_cmd(mk_cmd(FUNC_SET, POS_MAX, '0, '0, '0, 1'b0, 1'b0));
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, '0, '0, 1'b0, 1'b0));
        wait_drained();

        // zero tolerance: deadband is the goal alone
        write_reg(CFG_IDX_TOL, '0);
        write_reg(CFG_IDX_DUTY, {DUTY_W{1'b1}});
        @(negedge clk);
        push_cmd(mk_cmd(FUNC_SET, 32'sd7, -32'sd7, '0, '0, 1'b0, 1'b0));
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, 32'sd8, -32'sd6, 1'b0, 1'b0));
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, 32'sd7, -32'sd7, 1'b0, 1'b0));
        wait_drained();

        // widest tolerance, zero duty
        write_reg(CFG_IDX_TOL, {TOL_W{1'b1}});
        write_reg(CFG_IDX_DUTY, '0);
        @(negedge clk);
        push_cmd(mk_cmd(FUNC_SET, '0, '0, '0, '0, 1'b0, 1'b0));
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, 32'sd65535, -32'sd65535, 1'b0, 1'b0));
        push_cmd(mk_cmd(FUNC_SET, '0, '0, '0, '0, 1'b0, 1'b0));
        push_cmd(mk_cmd(FUNC_TICK, '0, '0, -32'sd65536, 32'sd65536, 1'b0, 1'b0));
        wait_drained();

        // random phases; the second phase parks the receiver while the sender streams
        run_phase(TOL_RESET, DUTY_RESET, 20, 20, 1'b0, 240);
        run_phase('0, {DUTY_W{1'b1}}, 0, 10, 1'b1, 240);
        run_phase({TOL_W{1'b1}}, '0, 30, 0, 1'b0, 240);
        run_phase(TOL_W'($urandom_range(0, 64)), DUTY_W'($urandom), 10, 10, 1'b0, 240);
        write_reg(CFG_IDX_SPARE2, DUTY_W'($urandom));   // dropped by the block
        write_reg(CFG_IDX_SPARE3, DUTY_W'($urandom));
        run_phase(TOL_W'($urandom), DUTY_W'($urandom), 40, 40, 1'b0, 240);
        // last stretch runs flat out
        run_phase(16'd1, 16'd1, 0, 0, 1'b0, 240);

        repeat (DRAIN_CYCLES) @(posedge clk);
        fail_cnt += motor_cmd_q.size();
        if (fail_cnt == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
